// ===== rtl/core/brb_pkg.sv =====
// Shared constants, opcodes, types and count helpers for the byte ring buffer.
package brb_pkg;

  localparam int DEPTH   = 1024;
  localparam int RESERVE = 1;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = PTR_W;
  localparam int AMT_W   = 11;
  localparam int DATA_W  = 8;
  localparam int SUM_W   = AMT_W + 1;
  localparam int ROOM    = DEPTH - RESERVE;

  localparam int IN_W    = 3 + DATA_W + AMT_W;
  localparam int IN_TW   = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W   = DATA_W + 1 + 2 * CNT_W;
  localparam int OUT_TW  = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    OP_PUSH     = 3'd0,
    OP_POP      = 3'd1,
    OP_PEEK     = 3'd2,
    OP_DROP     = 3'd3,
    OP_COMMIT   = 3'd4,
    OP_STORE_AT = 3'd5,
    OP_CLEAR    = 3'd6,
    OP_STATUS   = 3'd7
  } op_e;

  typedef struct packed {
    logic             rd_flag;
    logic             accepted;
    logic [CNT_W-1:0] used_count;
    logic [CNT_W-1:0] free_count;
  } meta_t;

  function automatic logic [CNT_W-1:0] used_of(logic [PTR_W-1:0] rp, logic [PTR_W-1:0] wp);
    logic [PTR_W:0] t;
    t = (PTR_W+1)'(DEPTH) - {1'b0, rp} + {1'b0, wp};
    if (wp >= rp) begin
      return CNT_W'(wp - rp);
    end
    return t[CNT_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] free_of(logic [CNT_W-1:0] used);
    logic [CNT_W:0] t;
    t = (CNT_W+1)'(ROOM) - {1'b0, used};
    if (({1'b0, used} + (CNT_W+1)'(RESERVE)) >= (CNT_W+1)'(DEPTH)) begin
      return '0;
    end
    return t[CNT_W-1:0];
  endfunction

endpackage

// ===== rtl/core/brb_core.sv =====
// Pointer state, operation decode and byte store of the ring buffer.
module brb_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          beat_i,
  input  logic [2:0]                    opcode_i,
  input  logic [brb_pkg::DATA_W-1:0]    data_byte_i,
  input  logic [brb_pkg::AMT_W-1:0]     amount_i,
  output brb_pkg::meta_t                meta_o,
  output logic [brb_pkg::DATA_W-1:0]    rdata_o
);

  localparam logic [brb_pkg::SUM_W-1:0] DepthSum = brb_pkg::SUM_W'(brb_pkg::DEPTH);

  logic [brb_pkg::DATA_W-1:0] mem [brb_pkg::DEPTH];
  logic [brb_pkg::DATA_W-1:0] rdata_q;

  logic [brb_pkg::PTR_W-1:0] rp_q, rp_d, wp_q, wp_d;
  logic [brb_pkg::CNT_W-1:0] used_cur, free_cur, used_nxt;
  logic [brb_pkg::AMT_W:0]   used_ext, free_ext, amt_ext;
  logic [brb_pkg::AMT_W-1:0] off;
  logic [brb_pkg::PTR_W-1:0] base, addr_wrap, addr;
  logic [brb_pkg::SUM_W-1:0] sum, sum_wrap;
  logic                      ok, we, re;
  brb_pkg::op_e              op;

  assign op       = brb_pkg::op_e'(opcode_i);
  assign used_cur = brb_pkg::used_of(rp_q, wp_q);
  assign free_cur = brb_pkg::free_of(used_cur);
  assign used_ext = (brb_pkg::AMT_W+1)'(used_cur);
  assign free_ext = (brb_pkg::AMT_W+1)'(free_cur);
  assign amt_ext  = {1'b0, amount_i};

  // One shared wrap adder: push/pop step by one, the rest offset by amount.
  always_comb begin
    off  = amount_i;
    base = wp_q;
    if (op == brb_pkg::OP_PUSH || op == brb_pkg::OP_POP) begin
      off = brb_pkg::AMT_W'(1);
    end
    if (op == brb_pkg::OP_POP || op == brb_pkg::OP_PEEK || op == brb_pkg::OP_DROP) begin
      base = rp_q;
    end
    sum       = brb_pkg::SUM_W'(base) + brb_pkg::SUM_W'(off);
    sum_wrap  = (sum >= DepthSum) ? sum - DepthSum : sum;
    addr_wrap = sum_wrap[brb_pkg::PTR_W-1:0];
  end

  always_comb begin
    ok   = 1'b0;
    we   = 1'b0;
    re   = 1'b0;
    rp_d = rp_q;
    wp_d = wp_q;
    addr = addr_wrap;
    case (op)
      brb_pkg::OP_PUSH: begin
        ok   = (free_cur != '0);
        we   = ok;
        addr = wp_q;
        if (ok) wp_d = addr_wrap;
      end
      brb_pkg::OP_POP: begin
        ok   = (used_cur != '0);
        re   = ok;
        addr = rp_q;
        if (ok) rp_d = addr_wrap;
      end
      brb_pkg::OP_PEEK: begin
        ok = (amt_ext < used_ext);
        re = ok;
      end
      brb_pkg::OP_DROP: begin
        ok = (amount_i != '0) && (amt_ext <= used_ext);
        if (ok) rp_d = addr_wrap;
      end
      brb_pkg::OP_COMMIT: begin
        ok = (amount_i != '0) && (amt_ext <= free_ext);
        if (ok) wp_d = addr_wrap;
      end
      brb_pkg::OP_STORE_AT: begin
        ok = (amt_ext < free_ext);
        we = ok;
      end
      brb_pkg::OP_CLEAR: begin
        ok   = 1'b1;
        rp_d = '0;
        wp_d = '0;
      end
      default: begin
        ok = 1'b1;
      end
    endcase
  end

  assign used_nxt          = brb_pkg::used_of(rp_d, wp_d);
  assign meta_o.rd_flag    = re;
  assign meta_o.accepted   = ok;
  assign meta_o.used_count = used_nxt;
  assign meta_o.free_count = brb_pkg::free_of(used_nxt);
  assign rdata_o           = rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q <= '0;
      wp_q <= '0;
    end else if (beat_i) begin
      rp_q <= rp_d;
      wp_q <= wp_d;
    end
  end

  // Read and write never hit the same byte within one beat.
  always_ff @(posedge clk_i) begin
    if (beat_i && we) mem[addr] <= data_byte_i;
    if (beat_i && re) rdata_q <= mem[addr];
  end

endmodule

// ===== rtl/core/byte_ring_buffer.sv =====
// Circular byte FIFO: one operation per input beat, one result beat per operation. Pointers
// are updated at acceptance and the byte store is read through its registered port; a result
// passes a pending register, then an output register that holds under back-pressure. A
// 1024-byte store keeps one slot empty, giving 1023 usable bytes. The store is not cleared by
// reset; popping or peeking a byte committed but never stored returns an unspecified value.
module byte_ring_buffer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_tvalid_i,
  output logic                        s_tready_o,
  // [2:0] opcode, [10:3] data_byte, [21:11] amount, rest zero
  input  logic [brb_pkg::IN_TW-1:0]   s_tdata_i,
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  // [7:0] read_data, [8] accepted, [18:9] used_count, [28:19] free_count, rest zero
  output logic [brb_pkg::OUT_TW-1:0]  m_tdata_o
);

  logic                       beat, p_move;
  logic                       p_valid_q, o_valid_q;
  brb_pkg::meta_t             meta, p_meta_q;
  logic [brb_pkg::DATA_W-1:0] rdata;
  logic [brb_pkg::OUT_W-1:0]  o_data_q, o_data_d;

  assign p_move     = p_valid_q && (!o_valid_q || m_tready_i);
  assign s_tready_o = !p_valid_q || p_move;
  assign beat       = s_tvalid_i && s_tready_o;

  brb_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .opcode_i    (s_tdata_i[2:0]),
    .data_byte_i (s_tdata_i[3 +: brb_pkg::DATA_W]),
    .amount_i    (s_tdata_i[3 + brb_pkg::DATA_W +: brb_pkg::AMT_W]),
    .meta_o      (meta),
    .rdata_o     (rdata)
  );

  assign o_data_d = {p_meta_q.free_count, p_meta_q.used_count, p_meta_q.accepted,
                     (p_meta_q.rd_flag ? rdata : '0)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (beat) p_valid_q <= 1'b1;
      else if (p_move) p_valid_q <= 1'b0;
      if (p_move) o_valid_q <= 1'b1;
      else if (m_tready_i) o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat) p_meta_q <= meta;
    if (p_move) o_data_q <= o_data_d;
  end

  assign m_tvalid_o = o_valid_q;
  assign m_tdata_o  = brb_pkg::OUT_TW'(o_data_q);

`ifndef SYNTH
  a_counts_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> ({1'b0, m_tdata_o[18:9]} + {1'b0, m_tdata_o[28:19]}
                    == (brb_pkg::CNT_W+1)'(brb_pkg::ROOM)))
    else $error("used plus free does not match usable depth");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tdata_o[8]) |-> (m_tdata_o[7:0] == '0))
    else $error("refused beat carries read data");

  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat && s_tdata_i[2:0] == brb_pkg::OP_CLEAR) |=>
      (p_valid_q && p_meta_q.used_count == '0 && p_meta_q.accepted))
    else $error("clear did not empty the buffer");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for byte_ring_buffer: shadow ring model predicts every result beat.
module tb_top;
  import brb_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DIRECTED_CNT = 25;
  localparam int RANDOM_CNT   = 1500;
  localparam int PRINT_CAP    = 40;

  typedef struct {
    logic [DATA_W-1:0] read_data;
    logic              accepted;
    logic [CNT_W-1:0]  used_count;
    logic [CNT_W-1:0]  free_count;
  } ring_result_t;

  class ring_scoreboard;
    logic [DATA_W-1:0] mem[DEPTH];
    bit                filled[DEPTH];
    int                rd_ptr = 0;
    int                wr_ptr = 0;
    int                mismatches = 0;
    int                beat_no = 0;
    ring_result_t      pending_q[$];

    function int used_now();
      return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : DEPTH - rd_ptr + wr_ptr;
    endfunction

    function int free_now();
      int u;
      u = used_now();
      return (u + RESERVE >= DEPTH) ? 0 : DEPTH - RESERVE - u;
    endfunction

    // keep pop/peek away from bytes that were committed but never stored
    function void steer(inout op_e op, inout logic [AMT_W-1:0] amt);
      int u;
      u = used_now();
      if (op == OP_POP && u >= 1 && !filled[rd_ptr]) begin
        op  = OP_DROP;
        amt = AMT_W'(1);
      end else if (op == OP_PEEK && int'(amt) < u && !filled[(rd_ptr + int'(amt)) % DEPTH]) begin
        amt = AMT_W'(u + $urandom_range(0, 16));
      end
    endfunction

    function void note_op(op_e op, logic [DATA_W-1:0] data, logic [AMT_W-1:0] amt);
      ring_result_t r;
      int used;
      int room;
      int a;
      int idx;
      used = used_now();
      room = free_now();
      a = int'(amt);
      r.read_data = '0;
      r.accepted  = 1'b0;
      case (op)
        OP_PUSH: begin
          if (room >= 1) begin
            mem[wr_ptr]    = data;
            filled[wr_ptr] = 1'b1;
            wr_ptr = (wr_ptr + 1) % DEPTH;
            r.accepted = 1'b1;
          end
        end
        OP_POP: begin
          if (used >= 1) begin
            r.read_data = mem[rd_ptr];
            rd_ptr = (rd_ptr + 1) % DEPTH;
            r.accepted = 1'b1;
          end
        end
        OP_PEEK: begin
          if (a < used) begin
            r.read_data = mem[(rd_ptr + a) % DEPTH];
            r.accepted = 1'b1;
          end
        end
        OP_DROP: begin
          if (a >= 1 && a <= used) begin
            rd_ptr = (rd_ptr + a) % DEPTH;
            r.accepted = 1'b1;
          end
        end
        OP_COMMIT: begin
          if (a >= 1 && a <= room) begin
            wr_ptr = (wr_ptr + a) % DEPTH;
            r.accepted = 1'b1;
          end
        end
        OP_STORE_AT: begin
          if (a < room) begin
            idx = (wr_ptr + a) % DEPTH;
            mem[idx]    = data;
            filled[idx] = 1'b1;
            r.accepted = 1'b1;
          end
        end
        OP_CLEAR: begin
          rd_ptr = 0;
          wr_ptr = 0;
          r.accepted = 1'b1;
        end
        default: begin
          r.accepted = 1'b1;
        end
      endcase
      r.used_count = CNT_W'(used_now());
      r.free_count = CNT_W'(free_now());
      pending_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      if (mismatches < PRINT_CAP) $display("[%0t] beat %0d: %s", $realtime, beat_no, msg);
      mismatches++;
    endtask

    task check_beat(logic [OUT_TW-1:0] beat);
      ring_result_t want;
      logic [DATA_W-1:0] got_rd;
      logic              got_acc;
      logic [CNT_W-1:0]  got_used;
      logic [CNT_W-1:0]  got_free;
      got_rd   = beat[DATA_W-1:0];
      got_acc  = beat[DATA_W];
      got_used = beat[DATA_W+CNT_W:DATA_W+1];
      got_free = beat[DATA_W+2*CNT_W:DATA_W+CNT_W+1];
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("result beat %h with nothing outstanding", beat));
      end else begin
        want = pending_q.pop_front();
        if (got_rd !== want.read_data)
          report_mismatch($sformatf("read_data %h, want %h", got_rd, want.read_data));
        if (got_acc !== want.accepted)
          report_mismatch($sformatf("accepted %b, want %b", got_acc, want.accepted));
        if (got_used !== want.used_count)
          report_mismatch($sformatf("used_count %0d, want %0d", got_used, want.used_count));
        if (got_free !== want.free_count)
          report_mismatch($sformatf("free_count %0d, want %0d", got_free, want.free_count));
      end
      beat_no++;
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_tvalid_i;
  logic                s_tready_o;
  logic [IN_TW-1:0]    s_tdata_i;
  logic                m_tvalid_o;
  logic                m_tready_i;
  logic [OUT_TW-1:0]   m_tdata_o;

  ring_scoreboard sb = new;
  int  cycles = 0;
  int  items_sent = 0;
  bit  src_idle_en = 1'b1;
  bit  sink_stall_en = 1'b1;
  int  stall_left = 0;

  byte_ring_buffer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // sink side: random back-pressure bursts
  initial begin
    m_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        m_tready_i <= 1'b0;
        stall_left--;
      end else if (sink_stall_en && $urandom_range(0, 5) == 0) begin
        m_tready_i <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        m_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) sb.check_beat(m_tdata_o);
  end

  // one operation per call; returns at the falling edge after its beat is taken
  task automatic send_item(op_e op, logic [DATA_W-1:0] data, logic [AMT_W-1:0] amt);
    sb.steer(op, amt);
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      s_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= IN_TW'({amt, data, op});
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    sb.note_op(op, data, amt);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic run_directed();
    send_item(OP_STATUS, 8'h00, 11'd0);
    send_item(OP_POP, 8'hff, 11'd0);                     // empty
    send_item(OP_PEEK, 8'h00, 11'd0);                    // empty
    send_item(OP_DROP, 8'h00, 11'd0);                    // zero count
    send_item(OP_COMMIT, 8'h00, 11'd0);                  // zero count
    send_item(OP_DROP, 8'h00, 11'd1);                    // beyond used
    send_item(OP_PUSH, 8'h00, 11'd0);
    send_item(OP_PUSH, 8'hff, 11'd2047);
    send_item(OP_STORE_AT, 8'h5a, 11'd0);
    send_item(OP_STORE_AT, 8'hc3, AMT_W'(sb.free_now() - 1));
    send_item(OP_STORE_AT, 8'h3c, AMT_W'(sb.free_now())); // offset not below free
    send_item(OP_COMMIT, 8'h00, 11'd1);
    send_item(OP_PEEK, 8'h00, 11'd2);
    send_item(OP_PEEK, 8'h00, AMT_W'(sb.used_now()));
    send_item(OP_PEEK, 8'h00, 11'd2047);
    send_item(OP_POP, 8'h00, 11'd0);
    send_item(OP_COMMIT, 8'h00, 11'd2047);
    send_item(OP_COMMIT, 8'h00, 11'd1024);
    send_item(OP_COMMIT, 8'h00, AMT_W'(sb.free_now())); // fills, write pointer wraps to 0
    send_item(OP_PUSH, 8'h81, 11'd0);                    // full
    send_item(OP_STORE_AT, 8'h81, 11'd0);                // full
    send_item(OP_DROP, 8'h00, AMT_W'(sb.used_now() + 1));
    send_item(OP_DROP, 8'h00, AMT_W'(sb.used_now()));
    send_item(OP_CLEAR, 8'h00, 11'd0);
    send_item(OP_STATUS, 8'h00, 11'd0);
  endtask

  task automatic run_random();
    int pick;
    int n;
    int u;
    int room;
    op_e op;
    while (items_sent < DIRECTED_CNT + RANDOM_CNT) begin
      if (items_sent > DIRECTED_CNT + (RANDOM_CNT * 4) / 5) begin
        src_idle_en   = 1'b0;
        sink_stall_en = 1'b0;
      end else begin
        src_idle_en   = ($urandom_range(0, 9) < 7);
        sink_stall_en = ($urandom_range(0, 9) < 7);
      end
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        n = $urandom_range(1, 48);
        repeat (n) send_item(OP_PUSH, DATA_W'($urandom), AMT_W'($urandom));
      end else if (pick < 38) begin
        n = $urandom_range(1, 48);
        repeat (n) send_item(OP_POP, DATA_W'($urandom), AMT_W'($urandom));
      end else if (pick < 55) begin
        // write a block in place, then publish it
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) send_item(OP_STORE_AT, DATA_W'($urandom), AMT_W'(i));
        send_item(OP_COMMIT, DATA_W'($urandom), AMT_W'(n));
      end else if (pick < 65) begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          u = sb.used_now();
          send_item(OP_PEEK, DATA_W'($urandom),
                    AMT_W'((u > 0) ? $urandom_range(0, u - 1) : 0));
        end
      end else if (pick < 72) begin
        u = sb.used_now();
        send_item(OP_DROP, DATA_W'($urandom), AMT_W'($urandom_range(1, (u > 0) ? u : 1)));
      end else if (pick < 78) begin
        // run up against the full boundary
        room = sb.free_now();
        send_item(OP_COMMIT, DATA_W'($urandom), AMT_W'(room - $urandom_range(0, 2)));
        n = $urandom_range(1, 4);
        repeat (n) send_item(OP_PUSH, DATA_W'($urandom), AMT_W'($urandom));
        room = sb.free_now();
        send_item(OP_STORE_AT, DATA_W'($urandom), AMT_W'(room - $urandom_range(0, 1)));
      end else if (pick < 80) begin
        send_item(OP_CLEAR, DATA_W'($urandom), AMT_W'($urandom));
      end else if (pick < 83) begin
        send_item(OP_STATUS, DATA_W'($urandom), AMT_W'($urandom));
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          op = op_e'($urandom_range(0, 7));
          u  = sb.used_now();
          if ($urandom_range(0, 1) == 0)
            send_item(op, DATA_W'($urandom), AMT_W'($urandom_range(0, 2047)));
          else
            send_item(op, DATA_W'($urandom), AMT_W'($urandom_range(0, u + 2)));
        end
      end
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    s_tvalid_i = 1'b0;
    s_tdata_i  = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    run_directed();
    run_random();
    s_tvalid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
